FILE: sv/lfu_block_cache_macros.svh
// Assertion macros for the LFU block cache.
// Included by the top level; no other dependencies.
`ifndef LFU_BLOCK_CACHE_MACROS_SVH
`define LFU_BLOCK_CACHE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lbc_pkg.sv
// Shared types, codes and helpers for the LFU block cache.
// No dependencies.
`timescale 1ns / 1ps
package lbc_pkg;

  localparam int SLOT_W_MAX = 12;
  localparam int BEAT_W_MAX = 6;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_INSERT = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [1:0]              status;
    logic [SLOT_W_MAX-1:0]   slot;
    logic [BEAT_W_MAX-1:0]   beat;
    logic [63:0]             word;
    logic                    emit;
    logic [31:0]             hits;
    logic [31:0]             looks;
  } cmd_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] tag;
    logic [31:0] uses;
  } meta_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

FILE: sv/lfu_block_cache.sv
// Top level of the LFU block cache: config register, front, queue, back.
// Depends on lbc_pkg, lbc_front, lbc_cmd_queue, lbc_back, macros header.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Payload
//  in_*      input      in_valid / in_ready    req_type, disk, block_index,
//                                              data_word, last_beat
//  out_*     output     out_valid / out_ready  status, read_word, last_out,
//                                              hit_count, query_count
//  cfg_*     input      cfg_valid / cfg_ready  cfg_data (entries_in_use)
//
//  Flow: a new request scans slot metadata one slot per cycle from the
//  metadata RAM over the first n slots, n = active slots. A write data
//  beat after the first is taken without a new scan. A lookup hit reads each
//  word through B_RD_WAIT and B_RD_DATA (block RAM read latency).
//  Reset: synchronous, active low; afterwards a clearing pass over all
//  CACHE_ENTRIES slots zeroes the metadata RAM with in_ready low.
//  Stalls: a two-entry transaction queue splits front and back, and the
//  result register takes a new transaction while out_ready is low only
//  after the held one leaves.
`include "lfu_block_cache_macros.svh"
module lfu_block_cache
  import lbc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16,
  parameter int BLOCK_WORDS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_disk,
  input  logic [7:0]  in_block_index,
  input  logic [63:0] in_data_word,
  input  logic        in_last_beat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_word,
  output logic        out_last_out,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_query_count
);

  // entries_in_use; zero disables the cache
  logic [4:0] eiu_r, eiu_nxt;
  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_cmd, q_head;

  assign cfg_ready = 1'b1;
  assign eiu_nxt   = (cfg_valid && cfg_ready) ? cfg_data : eiu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r <= '0;
    end else begin
      eiu_r <= eiu_nxt;
    end
  end

  // Front: classifies each transaction and does all metadata work
  lbc_front #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .BLOCK_WORDS   (BLOCK_WORDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .entries_in_use (eiu_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_disk        (in_disk),
    .in_block_index (in_block_index),
    .in_data_word   (in_data_word),
    .in_last_beat   (in_last_beat),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  lbc_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: block store writes, read streaming, result register
  lbc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .BLOCK_WORDS   (BLOCK_WORDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_word   (out_read_word),
    .out_last_out    (out_last_out),
    .out_hit_count   (out_hit_count),
    .out_query_count (out_query_count)
  );

  `LBC_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, q_push, !q_full || q_pop, "queue overflow")
  `LBC_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, q_pop, !q_empty, "queue underflow")
  `LBC_ASSERT_IMPL(a_nonhit_zero_word, clk, rst_n, out_valid && out_status != ST_OK, out_read_word == 64'd0 && out_last_out, "non-hit result carries data")

endmodule

FILE: sv/lbc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lbc_cmd_queue.sv
// Two-entry command queue between front and back.
// Depends on lbc_pkg.
`timescale 1ns / 1ps
module lbc_cmd_queue
  import lbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/lbc_front.sv
// Front end: accepts transactions, scans slot metadata, picks LFU victims,
// keeps the lookup counters and issues commands. Depends on lbc_pkg, lbc_ram.
`timescale 1ns / 1ps
module lbc_front
  import lbc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16,
  parameter int BLOCK_WORDS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  entries_in_use,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_disk,
  input  logic [7:0]  in_block_index,
  input  logic [63:0] in_data_word,
  input  logic        in_last_beat,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
  localparam int BEAT_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_SCAN, F_DONE} fstate_t;

  fstate_t          state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [1:0]       req_r, req_nxt;
  logic [11:0]      tag_r, tag_nxt;
  logic [63:0]      word_r, word_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             iss_r, iss_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [31:0]      hit_uses_r, hit_uses_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic             best_inv_r, best_inv_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]      best_uses_r, best_uses_nxt;
  logic [31:0]      hits_r, hits_nxt;
  logic [31:0]      looks_r, looks_nxt;
  logic             wr_act_r, wr_act_nxt;
  logic [IDX_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [BEAT_W-1:0] wr_beat_r, wr_beat_nxt;

  logic             meta_we;
  logic [IDX_W-1:0] meta_waddr;
  meta_t            meta_wdata;
  meta_t            meta_rdata;
  logic [CNT_W-1:0] active_cnt;
  logic             accept;
  logic             first_emit;

  lbc_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (scan_idx_r),
    .rdata (meta_rdata)
  );

  assign active_cnt = (32'(entries_in_use) > 32'(CACHE_ENTRIES)) ?
                      CNT_W'(CACHE_ENTRIES) : CNT_W'(entries_in_use);
  assign in_ready   = (state_r == F_IDLE) && !q_full;
  assign accept     = in_valid && in_ready;
  assign first_emit = last_r || (BLOCK_WORDS == 1);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    tag_nxt       = tag_r;
    word_nxt      = word_r;
    last_nxt      = last_r;
    n_nxt         = n_r;
    scan_idx_nxt  = scan_idx_r;
    iss_nxt       = iss_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_uses_nxt  = hit_uses_r;
    best_vld_nxt  = best_vld_r;
    best_inv_nxt  = best_inv_r;
    best_idx_nxt  = best_idx_r;
    best_uses_nxt = best_uses_r;
    hits_nxt      = hits_r;
    looks_nxt     = looks_r;
    wr_act_nxt    = wr_act_r;
    wr_slot_nxt   = wr_slot_r;
    wr_beat_nxt   = wr_beat_r;
    meta_we       = 1'b0;
    meta_waddr    = clr_idx_r;
    meta_wdata    = '0;
    q_push        = 1'b0;
    q_cmd         = '0;
    q_cmd.kind    = CMD_STATUS;

    unique case (state_r)
      F_CLEAR: begin
        meta_we = 1'b1;
        if (clr_idx_r == IDX_W'(CACHE_ENTRIES - 1)) begin
          state_nxt = F_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      F_IDLE: begin
        if (accept) begin
          q_cmd.hits  = hits_r;
          q_cmd.looks = looks_r;
          if (wr_act_r) begin
            // continuation beat of a running write
            q_push     = 1'b1;
            q_cmd.kind = CMD_WRITE;
            q_cmd.slot = SLOT_W_MAX'(wr_slot_r);
            q_cmd.beat = BEAT_W_MAX'(wr_beat_r);
            q_cmd.word = in_data_word;
            q_cmd.emit = in_last_beat || (wr_beat_r == BEAT_W'(BLOCK_WORDS - 1));
            if (q_cmd.emit) begin
              wr_act_nxt  = 1'b0;
              wr_beat_nxt = '0;
            end else begin
              wr_beat_nxt = wr_beat_r + BEAT_W'(1);
            end
          end else if (in_req_type == REQ_RSVD) begin
            state_nxt = F_IDLE;
          end else if (active_cnt == '0) begin
            q_push       = 1'b1;
            q_cmd.status = ST_DISABLED;
            q_cmd.emit   = 1'b1;
          end else begin
            req_nxt      = in_req_type;
            tag_nxt      = {in_disk, in_block_index};
            word_nxt     = in_data_word;
            last_nxt     = in_last_beat;
            n_nxt        = active_cnt;
            scan_idx_nxt = '0;
            iss_nxt      = 1'b1;
            hit_nxt      = 1'b0;
            best_vld_nxt = 1'b0;
            best_inv_nxt = 1'b0;
            state_nxt    = F_SCAN;
          end
        end
      end
      F_SCAN: begin
        if (iss_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_idx_r;
          if (CNT_W'(scan_idx_r) == n_r - CNT_W'(1)) begin
            iss_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
        if (chk_vld_r) begin
          if (meta_rdata.vld && meta_rdata.tag == tag_r && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = chk_idx_r;
            hit_uses_nxt = meta_rdata.uses;
          end
          if (!best_inv_r) begin
            if (!meta_rdata.vld) begin
              best_inv_nxt = 1'b1;
              best_vld_nxt = 1'b1;
              best_idx_nxt = chk_idx_r;
            end else if (!best_vld_r || meta_rdata.uses < best_uses_r) begin
              best_vld_nxt  = 1'b1;
              best_idx_nxt  = chk_idx_r;
              best_uses_nxt = meta_rdata.uses;
            end
          end
          if (CNT_W'(chk_idx_r) == n_r - CNT_W'(1)) begin
            state_nxt = F_DONE;
          end
        end
      end
      F_DONE: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_nxt  = F_IDLE;
          q_cmd.emit = 1'b1;
          priority if (req_r == REQ_LOOKUP) begin
            looks_nxt = sat_inc(looks_r);
            if (hit_r) begin
              hits_nxt        = sat_inc(hits_r);
              meta_we         = 1'b1;
              meta_waddr      = hit_idx_r;
              meta_wdata.vld  = 1'b1;
              meta_wdata.tag  = tag_r;
              meta_wdata.uses = sat_inc(hit_uses_r);
              q_cmd.kind      = CMD_READ;
              q_cmd.slot      = SLOT_W_MAX'(hit_idx_r);
            end else begin
              q_cmd.status = ST_MISS;
            end
          end else if ((req_r == REQ_UPDATE && hit_r) ||
                       (req_r != REQ_UPDATE && best_vld_r)) begin
            meta_we        = 1'b1;
            meta_wdata.vld = 1'b1;
            meta_wdata.tag = tag_r;
            if (req_r == REQ_UPDATE) begin
              meta_waddr      = hit_idx_r;
              meta_wdata.uses = sat_inc(hit_uses_r);
            end else begin
              meta_waddr      = best_idx_r;
              meta_wdata.uses = 32'd1;
            end
            q_cmd.kind  = CMD_WRITE;
            q_cmd.slot  = SLOT_W_MAX'(meta_waddr);
            q_cmd.beat  = '0;
            q_cmd.word  = word_r;
            q_cmd.emit  = first_emit;
            wr_slot_nxt = meta_waddr;
            wr_act_nxt  = !first_emit;
            wr_beat_nxt = first_emit ? '0 : BEAT_W'(1);
          end else if (req_r == REQ_UPDATE) begin
            q_cmd.status = ST_MISS;
          end else begin
            q_cmd.status = ST_NO_SLOT;
          end
          q_cmd.hits  = hits_nxt;
          q_cmd.looks = looks_nxt;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_CLEAR;
      clr_idx_r  <= '0;
      iss_r      <= 1'b0;
      chk_vld_r  <= 1'b0;
      hits_r     <= '0;
      looks_r    <= '0;
      wr_act_r   <= 1'b0;
      wr_slot_r  <= '0;
      wr_beat_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      iss_r      <= iss_nxt;
      chk_vld_r  <= chk_vld_nxt;
      hits_r     <= hits_nxt;
      looks_r    <= looks_nxt;
      wr_act_r   <= wr_act_nxt;
      wr_slot_r  <= wr_slot_nxt;
      wr_beat_r  <= wr_beat_nxt;
    end
    req_r       <= req_nxt;
    tag_r       <= tag_nxt;
    word_r      <= word_nxt;
    last_r      <= last_nxt;
    n_r         <= n_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_uses_r  <= hit_uses_nxt;
    best_vld_r  <= best_vld_nxt;
    best_inv_r  <= best_inv_nxt;
    best_idx_r  <= best_idx_nxt;
    best_uses_r <= best_uses_nxt;
  end

endmodule

FILE: sv/lbc_back.sv
// Back end: executes queued commands against the block store and drives
// the registered result channel. Depends on lbc_pkg, lbc_ram.
`timescale 1ns / 1ps
module lbc_back
  import lbc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16,
  parameter int BLOCK_WORDS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        q_head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_word,
  output logic        out_last_out,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_query_count
);

  localparam int IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int BEAT_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int BA_W   = $clog2(CACHE_ENTRIES * BLOCK_WORDS);

  typedef enum logic [1:0] {B_IDLE, B_RD_WAIT, B_RD_DATA} bstate_t;

  bstate_t           state_r, state_nxt;
  logic [IDX_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [BEAT_W-1:0] rd_beat_r, rd_beat_nxt;
  logic [31:0]       rd_hits_r, rd_hits_nxt;
  logic [31:0]       rd_looks_r, rd_looks_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [63:0]       out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;
  logic [31:0]       out_hits_r, out_hits_nxt;
  logic [31:0]       out_looks_r, out_looks_nxt;

  logic              out_free;
  logic              ram_we;
  logic [BA_W-1:0]   ram_waddr;
  logic [BA_W-1:0]   ram_raddr;
  logic [63:0]       ram_rdata;
  logic [IDX_W-1:0]  cmd_slot;
  logic [BEAT_W-1:0] cmd_beat;

  assign cmd_slot  = q_head.slot[IDX_W-1:0];
  assign cmd_beat  = q_head.beat[BEAT_W-1:0];
  assign ram_waddr = BA_W'(BA_W'(cmd_slot) * BA_W'(BLOCK_WORDS) + BA_W'(cmd_beat));
  assign ram_raddr = BA_W'(BA_W'(rd_slot_r) * BA_W'(BLOCK_WORDS) + BA_W'(rd_beat_r));

  lbc_ram #(
    .WIDTH (64),
    .DEPTH (CACHE_ENTRIES * BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_head.word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_word   = out_word_r;
  assign out_last_out    = out_last_r;
  assign out_hit_count   = out_hits_r;
  assign out_query_count = out_looks_r;

  always_comb begin
    state_nxt      = state_r;
    rd_slot_nxt    = rd_slot_r;
    rd_beat_nxt    = rd_beat_r;
    rd_hits_nxt    = rd_hits_r;
    rd_looks_nxt   = rd_looks_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    out_hits_nxt   = out_hits_r;
    out_looks_nxt  = out_looks_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            CMD_READ: begin
              q_pop        = 1'b1;
              rd_slot_nxt  = cmd_slot;
              rd_beat_nxt  = '0;
              rd_hits_nxt  = q_head.hits;
              rd_looks_nxt = q_head.looks;
              state_nxt    = B_RD_WAIT;
            end
            CMD_WRITE, CMD_STATUS: begin
              if (!q_head.emit || out_free) begin
                q_pop  = 1'b1;
                ram_we = (q_head.kind == CMD_WRITE);
                if (q_head.emit) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = (q_head.kind == CMD_WRITE) ? ST_OK : q_head.status;
                  out_word_nxt   = '0;
                  out_last_nxt   = 1'b1;
                  out_hits_nxt   = q_head.hits;
                  out_looks_nxt  = q_head.looks;
                end
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_RD_WAIT: state_nxt = B_RD_DATA;
      B_RD_DATA: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_word_nxt   = ram_rdata;
          out_last_nxt   = (rd_beat_r == BEAT_W'(BLOCK_WORDS - 1));
          out_hits_nxt   = rd_hits_r;
          out_looks_nxt  = rd_looks_r;
          if (out_last_nxt) begin
            state_nxt = B_IDLE;
          end else begin
            rd_beat_nxt = rd_beat_r + BEAT_W'(1);
            state_nxt   = B_RD_WAIT;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_slot_r    <= rd_slot_nxt;
    rd_beat_r    <= rd_beat_nxt;
    rd_hits_r    <= rd_hits_nxt;
    rd_looks_r   <= rd_looks_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
    out_hits_r   <= out_hits_nxt;
    out_looks_r  <= out_looks_nxt;
  end

endmodule
